// ----- design/mnpr_pkg.sv -----
// Package for the MIDI note pair recorder: word layouts, command and result
// codes, beat constants and the saturating beat adder.
// Used by the interfaces and the top level.
package mnpr_pkg;

    localparam int BEAT_W = 48;

    typedef logic [BEAT_W-1:0] beat_t;

    localparam beat_t BEAT_MAX       = {BEAT_W{1'b1}};
    localparam beat_t MIN_DURATION   = beat_t'(1) << 27;   // 1/32 beat in Q16.32
    localparam beat_t FLUSH_DURATION = beat_t'(1) << 29;   // 1/8 beat in Q16.32

    // Command codes carried in the cmd field
    localparam logic [1:0] CMD_ARM   = 2'd0;
    localparam logic [1:0] CMD_EVENT = 2'd1;
    localparam logic [1:0] CMD_BLOCK = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_CLOSED  = 2'd0;
    localparam logic [1:0] KIND_FLUSHED = 2'd1;
    localparam logic [1:0] KIND_DROPPED = 2'd2;

    // High nibble of the MIDI status byte
    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
    localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  status_byte;
        logic [6:0]  note_number;
        logic [6:0]  velocity_in;
        logic [15:0] sample_offset;
        logic [31:0] beats_per_sample;
        logic [15:0] block_samples;
    } event_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] note_out;
        beat_t      start_beat;
        beat_t      duration_beat;
        logic [6:0] velocity_out;
        logic       last;
    } note_word_t;

    // One entry of the held-note table
    typedef struct packed {
        logic [6:0] note;
        beat_t      start;
        logic [6:0] velocity;
    } held_entry_t;

    function automatic beat_t sat_add(beat_t a, beat_t b);
        logic [BEAT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BEAT_W] ? BEAT_MAX : s[BEAT_W-1:0];
    endfunction

endpackage

// ----- design/mnpr_if.sv -----
// Valid/ready channel interfaces for the MIDI note pair recorder.
// Depends on mnpr_pkg for the word layouts.
interface mnpr_event_if;
    logic                     valid;
    logic                     ready;
    mnpr_pkg::event_word_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mnpr_note_if;
    logic                     valid;
    logic                     ready;
    mnpr_pkg::note_word_t     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/mnpr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Stand-alone, no package dependency.
module mnpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/midi_note_pair_recorder.sv -----
// Top level of the MIDI note pair recorder: command sequencer around the
// held-note table. Depends on mnpr_pkg, mnpr_if.sv and mnpr_ram.
//
// Usage. Words arrive on the events channel and carry one of four commands:
// arm (clear the table and beat clock, start recording), MIDI event, end of
// block (advance the beat clock by block_samples * beats_per_sample) and stop
// (flush every held note). Finished notes leave on the notes channel, each
// with last set on the final note caused by one event word.
//
// Sequencing. Arm is handled in idle without leaving it. End of block and a
// note-on step through operand latch, multiply and saturating add, then set
// the beat clock or write the table; a full table makes a note-on load its
// dropped note instead. A note-off searches the table from the newest
// entry downwards, one entry a cycle, then closes the ranks above the hit
// one entry a cycle. A stop emits one note a cycle while the receiver keeps
// up. Every search, shift and flush walks the table through the single read
// port of the table RAM. The block takes the next word once the sequencer is
// back in idle, even while the last note still sits in the output register.
//
// Reset clears the sequencer, the entry count, the beat clock and the armed
// flag; the table contents need no clearing as only entries below the count
// are read. When the receiver stalls, the output register holds its note and
// the sequencer waits in a note-loading state, the table's read data held.
module midi_note_pair_recorder #(
    parameter int HELD_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    mnpr_event_if.sink        events,
    mnpr_note_if.source       notes
);

    localparam int IDX_W = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam int CNT_W = $clog2(HELD_DEPTH + 1);
    localparam int ENTRY_W = $bits(mnpr_pkg::held_entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_POS,
        S_EXEC,
        S_DROP,
        S_SRCH,
        S_HIT,
        S_SHIFT,
        S_FLUSH
    } state_t;

    // Sequencer and control state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    mnpr_pkg::beat_t     elapsed_reg, elapsed_next;
    logic                armed_reg, armed_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;

    // Latched word and arithmetic datapath
    logic [1:0]          cmd_reg, cmd_next;
    logic [7:0]          status_reg, status_next;
    logic [6:0]          note_reg, note_next;
    logic [6:0]          vel_reg, vel_next;
    logic [15:0]         mul_a_reg, mul_a_next;
    logic [31:0]         bps_reg, bps_next;
    mnpr_pkg::beat_t     prod_reg, prod_next;
    mnpr_pkg::beat_t     pos_reg, pos_next;
    mnpr_pkg::note_word_t out_reg, out_next;
    logic                out_load;

    // Table RAM ports
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    mnpr_pkg::held_entry_t rd_entry;

    // Helpers
    logic [CNT_W-1:0]    cnt_dec;
    logic [IDX_W-1:0]    last_idx;
    logic [IDX_W-1:0]    idx_inc;
    logic [IDX_W-1:0]    idx_inc2;
    logic [IDX_W-1:0]    idx_dec;
    logic                table_full;
    logic                out_free;
    logic [3:0]          status_hi;
    logic                is_note_on;
    logic                is_note_off;
    logic [mnpr_pkg::BEAT_W:0] diff;
    mnpr_pkg::beat_t     close_dur;

    mnpr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HELD_DEPTH)
    ) u_held_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry   = mnpr_pkg::held_entry_t'(ram_rdata);
    assign cnt_dec    = count_reg - CNT_W'(1);
    assign last_idx   = cnt_dec[IDX_W-1:0];
    assign idx_inc    = scan_idx_reg + IDX_W'(1);
    assign idx_inc2   = scan_idx_reg + IDX_W'(2);
    assign idx_dec    = scan_idx_reg - IDX_W'(1);
    assign table_full = (count_reg == CNT_W'(HELD_DEPTH));
    assign out_free   = !out_valid_reg || notes.ready;

    assign status_hi   = status_reg[7:4];
    assign is_note_on  = (status_hi == mnpr_pkg::STATUS_NOTE_ON) && (vel_reg != 7'd0);
    assign is_note_off = (status_hi == mnpr_pkg::STATUS_NOTE_OFF) ||
                         ((status_hi == mnpr_pkg::STATUS_NOTE_ON) && (vel_reg == 7'd0));

    // Duration of a closed note: position minus start, never under 1/32 beat.
    // A borrow means the position lies before the start.
    assign diff      = {1'b0, pos_reg} - {1'b0, rd_entry.start};
    assign close_dur = (!diff[mnpr_pkg::BEAT_W] &&
                        (diff[mnpr_pkg::BEAT_W-1:0] > mnpr_pkg::MIN_DURATION))
                       ? diff[mnpr_pkg::BEAT_W-1:0] : mnpr_pkg::MIN_DURATION;

    assign events.ready = (state_reg == S_IDLE);
    assign notes.valid  = out_valid_reg;
    assign notes.data   = out_reg;

    // Next-state logic. Table accesses never touch the same entry for read
    // and write in one cycle: the shift reads two entries ahead of the one it
    // writes, and a search or flush starts from a branch with no table write.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        elapsed_next  = elapsed_reg;
        armed_next    = armed_reg;
        scan_idx_next = scan_idx_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        note_next     = note_reg;
        vel_next      = vel_reg;
        mul_a_next    = mul_a_reg;
        bps_next      = bps_reg;
        prod_next     = mnpr_pkg::beat_t'(mul_a_reg) * mnpr_pkg::beat_t'(bps_reg);
        pos_next      = mnpr_pkg::sat_add(elapsed_reg, prod_reg);
        out_load      = 1'b0;
        out_next      = out_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[IDX_W-1:0];
        ram_wdata     = {note_reg, pos_reg, vel_reg};
        ram_re        = 1'b0;
        ram_raddr     = last_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (events.valid)
                begin
                    cmd_next    = events.data.cmd;
                    status_next = events.data.status_byte;
                    note_next   = events.data.note_number;
                    vel_next    = events.data.velocity_in;
                    bps_next    = events.data.beats_per_sample;
                    mul_a_next  = (events.data.cmd == mnpr_pkg::CMD_BLOCK)
                                  ? events.data.block_samples
                                  : events.data.sample_offset;
                    case (events.data.cmd)
                        mnpr_pkg::CMD_ARM:
                        begin
                            count_next   = '0;
                            elapsed_next = '0;
                            armed_next   = 1'b1;
                        end
                        mnpr_pkg::CMD_STOP:
                        begin
                            armed_next = 1'b0;
                            if (count_reg != '0)
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = '0;
                                scan_idx_next = '0;
                                state_next    = S_FLUSH;
                            end
                        end
                        default:
                        begin
                            if (armed_reg)
                            begin
                                state_next = S_MUL;
                            end
                        end
                    endcase
                end
            end

            S_MUL:
            begin
                state_next = S_POS;
            end

            S_POS:
            begin
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                if (cmd_reg == mnpr_pkg::CMD_BLOCK)
                begin
                    elapsed_next = pos_reg;
                end
                else if (is_note_on)
                begin
                    if (table_full)
                    begin
                        state_next = S_DROP;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (is_note_off && (count_reg != '0))
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = last_idx;
                    scan_idx_next = last_idx;
                    state_next    = S_SRCH;
                end
            end

            S_DROP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_next   = '{kind: mnpr_pkg::KIND_DROPPED, note_out: note_reg,
                                   start_beat: pos_reg, duration_beat: '0,
                                   velocity_out: vel_reg, last: 1'b1};
                    state_next = S_IDLE;
                end
            end

            S_SRCH:
            begin
                if (rd_entry.note == note_reg)
                begin
                    state_next = S_HIT;
                end
                else if (scan_idx_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = idx_dec;
                    scan_idx_next = idx_dec;
                end
            end

            S_HIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_next = '{kind: mnpr_pkg::KIND_CLOSED, note_out: note_reg,
                                 start_beat: rd_entry.start, duration_beat: close_dur,
                                 velocity_out: rd_entry.velocity, last: 1'b1};
                    if (scan_idx_reg == last_idx)
                    begin
                        count_next = cnt_dec;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = idx_inc;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // Move the entry just read down by one place
                ram_we    = 1'b1;
                ram_waddr = scan_idx_reg;
                ram_wdata = ram_rdata;
                if (idx_inc == last_idx)
                begin
                    count_next = cnt_dec;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = idx_inc2;
                    scan_idx_next = idx_inc;
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_next = '{kind: mnpr_pkg::KIND_FLUSHED, note_out: rd_entry.note,
                                 start_beat: rd_entry.start,
                                 duration_beat: mnpr_pkg::FLUSH_DURATION,
                                 velocity_out: rd_entry.velocity,
                                 last: (scan_idx_reg == last_idx)};
                    if (scan_idx_reg == last_idx)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re        = 1'b1;
                        ram_raddr     = idx_inc;
                        scan_idx_next = idx_inc;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (notes.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            elapsed_reg   <= '0;
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            elapsed_reg   <= elapsed_next;
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
            scan_idx_reg  <= scan_idx_next;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        note_reg   <= note_next;
        vel_reg    <= vel_next;
        mul_a_reg  <= mul_a_next;
        bps_reg    <= bps_next;
        prod_reg   <= prod_next;
        pos_reg    <= pos_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    // The entry count never exceeds the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HELD_DEPTH))
        else $error("held entry count above table depth");

    // Read and write of the table never hit the same entry in one cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("table read and write collide");

    // A dropped note-on is only reported while the table is full.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DROP) |-> table_full)
        else $error("note-on dropped with room in the table");

    // Once a flush completes the table is empty.
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && state_next == S_IDLE) |=> (count_reg == '0))
        else $error("table not empty after flush");

    // A search, hit, shift or flush never runs with an empty table.
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH || state_reg == S_HIT || state_reg == S_SHIFT ||
         state_reg == S_FLUSH) |-> (count_reg != '0))
        else $error("table walk with no held entries");

endmodule
